// ----- sv/sfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, widths and helpers for the sprite sheet frame animator.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int TIME_BITS  = 24;
  localparam int MAX_FRAMES = 256;

  localparam int TIME_W   = TIME_BITS + 1;         // animation time, one spare bit
  localparam int DELTA_W  = 20;
  localparam int FCNT_W   = 9;                     // frame_count register
  localparam int FC_W     = $clog2(MAX_FRAMES + 1); // clamped frame count
  localparam int IDX_W    = $clog2(MAX_FRAMES);
  localparam int PROD_W   = TIME_BITS + FC_W;      // time * count
  localparam int CELL_W   = 17;                    // first_cell + index
  localparam int FIRST_W  = 16;
  localparam int DIM_W    = 12;
  localparam int COORD_W  = 16;
  localparam int FRAME_W  = 8;
  localparam int RWIDTH_W = 13;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 72;
  localparam int FLD_W  = FRAME_W + 2 * COORD_W + RWIDTH_W + DIM_W + 1;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // reset values of the registers
  localparam logic [TIME_BITS-1:0] DURATION_RST = TIME_BITS'(1000000);
  localparam logic [DIM_W-1:0]     CELL_DIM_RST = DIM_W'(16);

  typedef enum logic [2:0] {
    REG_DURATION  = 3'd0,
    REG_REPEAT    = 3'd1,
    REG_FRAMES    = 3'd2,
    REG_FIRST     = 3'd3,
    REG_PER_ROW   = 3'd4,
    REG_CELL_W    = 3'd5,
    REG_CELL_H    = 3'd6
  } sfa_reg_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] duration_us;
    logic                 repeat_mode;
    logic [FCNT_W-1:0]    frame_count;
    logic [FIRST_W-1:0]   first_cell;
    logic [DIM_W-1:0]     cells_per_row;
    logic [DIM_W-1:0]     cell_width;
    logic [DIM_W-1:0]     cell_height;
  } sfa_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] anim_time;
    logic              flip;
  } sfa_tick_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PROD,
    B_SEL,
    B_WAIT1,
    B_CELL,
    B_WAIT2,
    B_RECT,
    B_FIN
  } sfa_back_state_t;

  // 0 counts as 1, anything above MAX_FRAMES as MAX_FRAMES
  function automatic logic [FC_W-1:0] clamp_count(input logic [FCNT_W-1:0] fc);
    logic [31:0] fc_ext;
    fc_ext = 32'(fc);
    if (fc_ext == 32'd0) begin
      clamp_count = FC_W'(1);
    end else if (fc_ext > 32'(MAX_FRAMES)) begin
      clamp_count = FC_W'(MAX_FRAMES);
    end else begin
      clamp_count = FC_W'(fc_ext);
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/sfa_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_front
// Takes ticks, advances the animation time and queues a snapshot per tick.
// ----------------------------------------------------------------------------
module sfa_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sfa_pkg::sfa_cfg_t        cfg,
  input  wire logic                     in_valid,
  input  wire logic [sfa_pkg::IN_W-1:0] in_data,
  output logic                          in_ready,
  input  wire logic                     q_full,
  output logic                          push,
  output sfa_pkg::sfa_tick_t            push_entry
);
  import sfa_pkg::*;

  localparam int SUM_W = ((TIME_W > DELTA_W) ? TIME_W : DELTA_W) + 1;

  logic [TIME_W-1:0]  anim_time;
  logic [TIME_W-1:0]  anim_time_next;
  logic [DELTA_W-1:0] delta;
  logic               restart;
  logic               flip;
  logic               at_end;
  logic               hold;
  logic [TIME_W-1:0]  base;
  logic [SUM_W-1:0]   sum;

  assign delta   = in_data[DELTA_W-1:0];
  assign restart = in_data[DELTA_W];
  assign flip    = in_data[DELTA_W+1];

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    at_end = anim_time >= TIME_W'(cfg.duration_us);
    hold   = at_end && !cfg.repeat_mode;
    base   = (at_end && cfg.repeat_mode) ? anim_time - TIME_W'(cfg.duration_us) : anim_time;
    sum    = SUM_W'(base) + SUM_W'(delta);
    if (restart) begin
      anim_time_next = '0;
    end else if (hold) begin
      anim_time_next = anim_time;
    end else if (|sum[SUM_W-1:TIME_W]) begin
      anim_time_next = {TIME_W{1'b1}};   // saturate
    end else begin
      anim_time_next = sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_time <= '0;
    end else if (push) begin
      anim_time <= anim_time_next;
    end
  end

  assign push_entry.anim_time = anim_time_next;
  assign push_entry.flip      = flip;

endmodule
`default_nettype wire

// ----- sv/sfa_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_queue
// Short register queue between the tick front end and the frame back end.
// ----------------------------------------------------------------------------
module sfa_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sfa_pkg::sfa_tick_t push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    valid,
  output sfa_pkg::sfa_tick_t      entry
);
  import sfa_pkg::*;

  sfa_tick_t           slots [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign full  = fill == QCNT_W'(Q_DEPTH);
  assign valid = fill != '0;
  assign entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/sfa_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module sfa_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [sfa_pkg::PROD_W-1:0]    dividend,
  input  wire logic [sfa_pkg::TIME_BITS-1:0] divisor,
  output logic                               done,
  output logic [sfa_pkg::PROD_W-1:0]         quot,
  output logic [sfa_pkg::TIME_BITS-1:0]      rem
);
  import sfa_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [PROD_W-1:0]    num;
  logic [TIME_BITS-1:0] part;
  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS:0]   trial;
  logic                 ge;

  assign trial = {part, num[PROD_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign quot  = num;
  assign rem   = part;

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      den  <= divisor;
      part <= '0;
    end else if (busy) begin
      part <= ge ? TIME_BITS'(trial - {1'b0, den}) : TIME_BITS'(trial);
      num  <= {num[PROD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/sfa_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_back
// Turns a queued time snapshot into frame index and sheet rectangle.
// ----------------------------------------------------------------------------
module sfa_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sfa_pkg::sfa_cfg_t         cfg,
  input  wire logic                      q_valid,
  input  wire sfa_pkg::sfa_tick_t        q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [sfa_pkg::OUT_W-1:0]      out_data
);
  import sfa_pkg::*;

  sfa_back_state_t      state;
  sfa_back_state_t      state_next;

  sfa_tick_t            tick;
  logic                 fin;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     index;
  logic [CELL_W-1:0]    row;
  logic [DIM_W-1:0]     col;
  logic [2*DIM_W-1:0]   left_raw;
  logic [DIM_W+CELL_W-1:0] top_raw;

  logic [FC_W-1:0]      count;
  logic [DIM_W-1:0]     cpr;
  logic [CELL_W-1:0]    cell_idx;

  logic                 div_start;
  logic [PROD_W-1:0]    div_dividend;
  logic [TIME_BITS-1:0] div_divisor;
  logic                 div_done;
  logic [PROD_W-1:0]    div_quot;
  logic [TIME_BITS-1:0] div_rem;

  logic [COORD_W-1:0]   left_sat;
  logic [COORD_W:0]     left_flip;
  logic [COORD_W-1:0]   rect_left;
  logic [COORD_W-1:0]   rect_top;
  logic [RWIDTH_W-1:0]  rect_width;
  logic                 load_out;

  assign count    = clamp_count(cfg.frame_count);
  assign cpr      = (cfg.cells_per_row == '0) ? DIM_W'(1) : cfg.cells_per_row;
  assign cell_idx = CELL_W'(cfg.first_cell) + CELL_W'(index);

  sfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    load_out     = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_PROD;
        end
      end
      B_PROD: state_next = B_SEL;
      B_SEL: begin
        if (cfg.duration_us == '0 || fin) begin
          state_next = B_CELL;
        end else begin
          div_start    = 1'b1;
          div_dividend = prod;
          div_divisor  = cfg.duration_us;
          state_next   = B_WAIT1;
        end
      end
      B_WAIT1: begin
        if (div_done) begin
          state_next = B_CELL;
        end
      end
      B_CELL: begin
        div_start    = 1'b1;
        div_dividend = PROD_W'(cell_idx);
        div_divisor  = TIME_BITS'(cpr);
        state_next   = B_WAIT2;
      end
      B_WAIT2: begin
        if (div_done) begin
          state_next = B_RECT;
        end
      end
      B_RECT: state_next = B_FIN;
      B_FIN: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          tick <= q_entry;
        end
      end
      B_PROD: begin
        fin  <= tick.anim_time >= TIME_W'(cfg.duration_us);
        prod <= PROD_W'(tick.anim_time[TIME_BITS-1:0]) * PROD_W'(count);
      end
      B_SEL: begin
        if (cfg.duration_us == '0) begin
          index <= '0;
        end else if (fin) begin
          index <= IDX_W'(count - FC_W'(1));
        end
      end
      B_WAIT1: begin
        if (div_done) begin
          index <= div_quot[IDX_W-1:0];
        end
      end
      B_WAIT2: begin
        if (div_done) begin
          row <= div_quot[CELL_W-1:0];
          col <= div_rem[DIM_W-1:0];
        end
      end
      B_RECT: begin
        left_raw <= (2*DIM_W)'(cfg.cell_width) * (2*DIM_W)'(col);
        top_raw  <= (DIM_W+CELL_W)'(cfg.cell_height) * (DIM_W+CELL_W)'(row);
      end
      default: ;
    endcase
  end

  // saturate to 16 bits, then the flip offset saturates again
  always_comb begin
    left_sat  = (|left_raw[2*DIM_W-1:COORD_W]) ? {COORD_W{1'b1}} : left_raw[COORD_W-1:0];
    rect_top  = (|top_raw[DIM_W+CELL_W-1:COORD_W]) ? {COORD_W{1'b1}}
                                                  : top_raw[COORD_W-1:0];
    left_flip = (COORD_W+1)'(left_sat) + (COORD_W+1)'(cfg.cell_width);
    if (tick.flip) begin
      rect_left  = left_flip[COORD_W] ? {COORD_W{1'b1}} : left_flip[COORD_W-1:0];
      rect_width = RWIDTH_W'(0) - RWIDTH_W'(cfg.cell_width);
    end else begin
      rect_left  = left_sat;
      rect_width = RWIDTH_W'(cfg.cell_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {(OUT_W-FLD_W)'(0), fin, cfg.cell_height, rect_width, rect_top,
                   rect_left, FRAME_W'(index)};
    end
  end

  a_quot_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_WAIT1 && div_done) |-> (div_quot < PROD_W'(count)))
    else $error("frame quotient not below frame count");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIN && out_valid && !out_ready) |=> (state == B_FIN))
    else $error("result lost while output stalled");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_FIN))
    else $error("output word raised outside result step");

endmodule
`default_nettype wire

// ----- sv/sprite_sheet_frame_animator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_sheet_frame_animator_unit
// Sprite sheet animation sequencer: animation time, frame index, cell rectangle.
// ----------------------------------------------------------------------------
// One input word per displayed frame arrives on the s_ stream (delta time,
// restart, flip). The front end advances the animation time in the cycle the
// word is taken and queues a snapshot in a two-entry queue; it keeps taking
// words while the queue has room. The back end works one snapshot at a time:
// a multiply, a 33-step division for the frame index (skipped when the
// animation has finished or the duration is zero), a 33-step division of the
// cell number by the cells per row, a multiply for the rectangle, then the
// result word is loaded into the m_ output register.
// Both divisions run on the one shared bit-serial divider.
// The result is held in the output register while m_tready is low, and the
// back end waits behind it; the queue then fills and s_tready drops.
// Reset (rst, synchronous) clears the time to zero, empties the queue and
// output, and loads the register defaults. The user must write the APB port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sprite_sheet_frame_animator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // lowest bit up: delta_us[19:0], restart, flip, zero pad
  input  wire logic [sfa_pkg::IN_W-1:0]    s_tdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // lowest bit up: frame_index[7:0], rect_left[15:0], rect_top[15:0],
  // rect_width[12:0], rect_height[11:0], finished, zero pad
  output logic [sfa_pkg::OUT_W-1:0]        m_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sfa_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sfa_pkg::DATA_W-1:0]  pwdata,
  output logic [sfa_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sfa_pkg::*;

  sfa_cfg_t   cfg;
  sfa_reg_e   reg_sel;
  logic       wr_en;

  logic       q_full;
  logic       q_push;
  sfa_tick_t  q_push_entry;
  logic       q_pop;
  logic       q_valid;
  sfa_tick_t  q_entry;

  assign pready  = 1'b1;
  assign reg_sel = sfa_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duration_us   <= DURATION_RST;
      cfg.repeat_mode   <= 1'b1;
      cfg.frame_count   <= FCNT_W'(1);
      cfg.first_cell    <= '0;
      cfg.cells_per_row <= DIM_W'(1);
      cfg.cell_width    <= CELL_DIM_RST;
      cfg.cell_height   <= CELL_DIM_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DURATION: cfg.duration_us   <= pwdata[TIME_BITS-1:0];
        REG_REPEAT:   cfg.repeat_mode   <= pwdata[0];
        REG_FRAMES:   cfg.frame_count   <= pwdata[FCNT_W-1:0];
        REG_FIRST:    cfg.first_cell    <= pwdata[FIRST_W-1:0];
        REG_PER_ROW:  cfg.cells_per_row <= pwdata[DIM_W-1:0];
        REG_CELL_W:   cfg.cell_width    <= pwdata[DIM_W-1:0];
        REG_CELL_H:   cfg.cell_height   <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DURATION: prdata = DATA_W'(cfg.duration_us);
      REG_REPEAT:   prdata = DATA_W'(cfg.repeat_mode);
      REG_FRAMES:   prdata = DATA_W'(cfg.frame_count);
      REG_FIRST:    prdata = DATA_W'(cfg.first_cell);
      REG_PER_ROW:  prdata = DATA_W'(cfg.cells_per_row);
      REG_CELL_W:   prdata = DATA_W'(cfg.cell_width);
      REG_CELL_H:   prdata = DATA_W'(cfg.cell_height);
      default:      prdata = '0;
    endcase
  end

  sfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_data    (s_tdata),
    .in_ready   (s_tready),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  sfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .entry      (q_entry)
  );

  sfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite sheet frame animator testbench
// Sends tick words on the s_ stream and checks every result word on the m_
// stream against an in-bench predictor of animation time, frame index and
// cell rectangle. A directed table comes first, then random phases, each with
// fresh register settings written over APB while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import sfa_pkg::*;

  localparam longint unsigned CLOCK_MAX = (64'd1 << TIME_W) - 1;
  localparam longint unsigned COORD_MAX = 65535;
  localparam bit [19:0]       DELTA_MAX = 20'hFFFFF;
  localparam int              NO_REG    = 7;    // decodes to no register
  localparam int              RAND_TICKS = 900;
  localparam int              QUIET_FROM = 760; // no idling past this point

  typedef struct {
    bit [7:0]  frame_index;
    bit [15:0] rect_left;
    bit [15:0] rect_top;
    bit [12:0] rect_width;
    bit [11:0] rect_height;
    bit        finished;
  } frame_t;

  typedef enum bit {ROW_WRITE, ROW_TICK} row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        reg_idx;
    bit [31:0] value;
    bit [19:0] delta;
    bit        restart;
    bit        flip;
    bit        typed;
    frame_t    want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic [IN_W-1:0]     s_tdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor copy of the registers and the animation time
  bit [23:0]           cfg_duration;
  bit                  cfg_repeat;
  bit [8:0]            cfg_frames;
  bit [15:0]           cfg_first;
  bit [11:0]           cfg_per_row;
  bit [11:0]           cfg_cell_w;
  bit [11:0]           cfg_cell_h;
  bit [TIME_W-1:0]     anim_clock;

  frame_t              frames_due[$];
  script_row_t         script[$];
  frame_t              no_frame;
  int                  n_fail;
  int                  rand_sent;
  bit                  idle_on;
  int                  stall_left;

  sprite_sheet_frame_animator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned clip_coord(longint unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic void apply_reg(int idx, bit [31:0] v);
    case (idx)
      REG_DURATION: cfg_duration = v[23:0];
      REG_REPEAT:   cfg_repeat   = v[0];
      REG_FRAMES:   cfg_frames   = v[8:0];
      REG_FIRST:    cfg_first    = v[15:0];
      REG_PER_ROW:  cfg_per_row  = v[11:0];
      REG_CELL_W:   cfg_cell_w   = v[11:0];
      REG_CELL_H:   cfg_cell_h   = v[11:0];
      default: ;
    endcase
  endfunction

  // advances the animation time by one tick and forms the frame shown
  function automatic frame_t next_frame(bit [19:0] delta, bit restart, bit flip);
    longint unsigned t, count, index, cpr, cell_no, left, top;
    bit done;
    frame_t f;
    t = anim_clock;
    if (restart) begin
      t = 0;
    end else if (t < cfg_duration || cfg_repeat) begin
      if (t >= cfg_duration) t = t - cfg_duration;
      t = t + delta;
      if (t > CLOCK_MAX) t = CLOCK_MAX;
    end
    anim_clock = TIME_W'(t);

    count = (cfg_frames == 0) ? 1 : (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : cfg_frames;
    done = (t >= cfg_duration);
    if (cfg_duration == 0) index = 0;
    else if (done) index = count - 1;
    else index = (t * count) / cfg_duration;

    cpr     = (cfg_per_row == 0) ? 1 : cfg_per_row;
    cell_no = cfg_first + index;
    left    = clip_coord(cfg_cell_w * (cell_no % cpr));
    top     = clip_coord(cfg_cell_h * (cell_no / cpr));

    f.frame_index = 8'(index);
    if (flip) begin
      f.rect_left  = 16'(clip_coord(left + cfg_cell_w));
      f.rect_width = 13'(0 - cfg_cell_w);
    end else begin
      f.rect_left  = 16'(left);
      f.rect_width = 13'(cfg_cell_w);
    end
    f.rect_top    = 16'(top);
    f.rect_height = cfg_cell_h;
    f.finished    = done;
    return f;
  endfunction

  function automatic void row_write(int idx, bit [31:0] v);
    script_row_t r;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.value = v;
    script = {script, r};
  endfunction

  function automatic void row_tick(bit [19:0] d, bit rs, bit fl);
    script_row_t r;
    r.kind = ROW_TICK;
    r.delta = d;
    r.restart = rs;
    r.flip = fl;
    r.typed = 1'b0;
    script = {script, r};
  endfunction

  function automatic void row_seen(bit [19:0] d, bit rs, bit fl, bit [7:0] idx,
                                   bit [15:0] lft, bit [15:0] tp, bit [12:0] w,
                                   bit [11:0] h, bit fin);
    script_row_t r;
    r.kind = ROW_TICK;
    r.delta = d;
    r.restart = rs;
    r.flip = fl;
    r.typed = 1'b1;
    r.want = '{idx, lft, tp, w, h, fin};
    script = {script, r};
  endfunction

  // entered just after a rising edge; valid is left high on return
  task automatic send_tick(bit [19:0] d, bit rs, bit fl, bit typed, frame_t want);
    int gap;
    frame_t f;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, fl, rs, d};
    do @(posedge clk); while (!s_tready);
    f = next_frame(d, rs, fl);
    if (typed) f = want;
    frames_due = {frames_due, f};
  endtask

  // waits until every result word is back, then writes one register
  task automatic apb_write(int idx, bit [31:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // field in the low bits, junk above it half the time
  task automatic write_field(int idx, bit [31:0] field, int width);
    bit [31:0] mask;
    mask = (width >= 32) ? 32'hFFFFFFFF : ((32'd1 << width) - 1);
    apb_write(idx, ($urandom_range(0, 1) ? ($urandom & ~mask) : 32'd0) | (field & mask));
  endtask

  task automatic random_settings();
    bit [31:0] v;
    case ($urandom_range(0, 11))
      0:       v = 0;
      1:       v = 24'hFFFFFF;
      2, 3:    v = $urandom_range(1, 64);
      4, 5, 6: v = $urandom_range(100, 5000);
      default: v = $urandom & 32'hFFFFFF;
    endcase
    write_field(REG_DURATION, v, 24);
    write_field(REG_REPEAT, $urandom_range(0, 3) != 0, 1);
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = $urandom_range(257, 511);
      2:       v = 256;
      default: v = $urandom_range(1, 40);
    endcase
    write_field(REG_FRAMES, v, 9);
    case ($urandom_range(0, 5))
      0:       v = 65535;
      1:       v = $urandom & 32'hFFFF;
      default: v = $urandom_range(0, 200);
    endcase
    write_field(REG_FIRST, v, 16);
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 4095;
      2:       v = $urandom & 32'hFFF;
      default: v = $urandom_range(1, 16);
    endcase
    write_field(REG_PER_ROW, v, 12);
    write_field(REG_CELL_W, ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 0 : 4095)
                                                         : $urandom_range(1, 64), 12);
    write_field(REG_CELL_H, ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 0 : 4095)
                                                         : $urandom_range(1, 64), 12);
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // result word checker
  always @(posedge clk) begin
    frame_t f;
    if (!rst && m_tvalid && m_tready) begin
      if (frames_due.size() == 0) begin
        $error("result word with no tick outstanding: %h", m_tdata);
        n_fail++;
      end else begin
        f = frames_due.pop_front();
        check_field("frame_index", f.frame_index, m_tdata[7:0]);
        check_field("rect_left",   f.rect_left,   m_tdata[23:8]);
        check_field("rect_top",    f.rect_top,    m_tdata[39:24]);
        check_field("rect_width",  f.rect_width,  m_tdata[52:40]);
        check_field("rect_height", f.rect_height, m_tdata[64:53]);
        check_field("finished",    f.finished,    m_tdata[65]);
      end
    end
  end

  // output back-pressure in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n, style;
    bit [19:0] d;
    rst      = 1'b1;
    s_tdata  = '0;
    s_tvalid = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    n_fail   = 0;
    rand_sent = 0;
    stall_left = 0;
    idle_on  = 1'b1;
    no_frame = '{0, 0, 0, 0, 0, 0};
    cfg_duration = 24'd1000000;
    cfg_repeat   = 1'b1;
    cfg_frames   = 9'd1;
    cfg_first    = 16'd0;
    cfg_per_row  = 12'd1;
    cfg_cell_w   = 12'd16;
    cfg_cell_h   = 12'd16;
    anim_clock   = '0;

    // reset defaults, flip, finish on a long delta, restart
    row_seen(0, 0, 0, 0, 0, 0, 13'd16, 16, 0);
    row_seen(0, 0, 1, 0, 16, 0, 13'h1FF0, 16, 0);
    row_seen(DELTA_MAX, 0, 0, 0, 0, 0, 13'd16, 16, 1);
    row_seen(0, 1, 1, 0, 16, 0, 13'h1FF0, 16, 0);
    // one-shot: runs to the last frame and holds there
    row_write(REG_DURATION, 100);
    row_write(REG_FRAMES, 10);
    row_write(REG_PER_ROW, 4);
    row_write(REG_REPEAT, 0);
    row_tick(55, 0, 0);
    row_tick(45, 0, 1);
    row_tick(DELTA_MAX, 0, 0);
    row_tick(0, 1, 0);
    // looping wraps past the duration
    row_write(REG_REPEAT, 1);
    row_tick(150, 0, 0);
    row_tick(10, 0, 0);
    // frame count of zero, then above the maximum; longest duration
    row_write(REG_FRAMES, 0);
    row_tick(30, 0, 0);
    row_write(REG_FRAMES, 511);
    row_write(REG_DURATION, 24'hFFFFFF);
    row_tick(DELTA_MAX, 1, 0);
    row_tick(DELTA_MAX, 0, 1);
    // coordinates past 65535
    row_write(REG_FIRST, 65535);
    row_write(REG_PER_ROW, 4095);
    row_write(REG_CELL_W, 4095);
    row_write(REG_CELL_H, 4095);
    row_tick(0, 0, 0);
    row_tick(0, 0, 1);
    row_write(REG_PER_ROW, 0);
    row_tick(0, 0, 0);
    row_tick(0, 0, 1);
    // empty cells, a write to no register, zero duration
    row_write(REG_CELL_W, 0);
    row_write(REG_CELL_H, 0);
    row_tick(0, 0, 1);
    row_write(NO_REG, 32'hFFFFFFFF);
    row_tick(5, 0, 0);
    row_write(REG_DURATION, 0);
    row_write(REG_FIRST, 0);
    row_write(REG_CELL_W, 16);
    row_write(REG_CELL_H, 16);
    row_tick(DELTA_MAX, 0, 1);
    row_tick(0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        apb_write(script[i].reg_idx, script[i].value);
      end else begin
        send_tick(script[i].delta, script[i].restart, script[i].flip,
                  script[i].typed, script[i].want);
      end
    end

    while (rand_sent < RAND_TICKS) begin
      random_settings();
      idle_on = (rand_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 70);
      style = $urandom_range(0, 5);
      for (int k = 0; k < n; k++) begin
        case (style)
          0, 1, 2: d = 20'($urandom_range(0, (cfg_duration / 4 + 1 > DELTA_MAX) ?
                                             DELTA_MAX : cfg_duration / 4 + 1));
          3, 4:    d = 20'($urandom);
          default: d = ($urandom_range(0, 3) == 0) ? 20'($urandom) : DELTA_MAX;
        endcase
        send_tick(d, $urandom_range(0, 24) == 0, $urandom_range(0, 1), 1'b0, no_frame);
        rand_sent++;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
